>>> rtl/core/software_timer_table_top_assert.svh
// Assertion macros shared by the timer table modules.
// Each expects clk_i and rst_ni in scope.
`ifndef SOFTWARE_TIMER_TABLE_TOP_ASSERT_SVH
`define SOFTWARE_TIMER_TABLE_TOP_ASSERT_SVH

// plain property, checked every clock outside reset
`define STT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define STT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/stt_pkg.sv
package stt_pkg;

  localparam int SLOTS     = 16;
  localparam int TIME_BITS = 32;

  // fixed field widths of the ports
  localparam int KIND_W  = 2;
  localparam int SLOT_W  = 4;
  localparam int FIELD_W = 32;

  localparam int SLOT_IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STOP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_START,
    OP_STOP,
    OP_TICK
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [SLOT_IW-1:0]   slot;
    logic [TIME_BITS-1:0] deadline;
    logic [TIME_BITS-1:0] period;
    logic                 periodic;
    logic [TIME_BITS-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic               fired;
    logic [SLOT_W-1:0]  fired_slot;
    logic               next_valid;
    logic [FIELD_W-1:0] next_due;
    logic               last;
  } res_t;

endpackage

>>> rtl/core/software_timer_table_top.sv
// Timer slot table. Start, stop and tick transactions enter through a queue
// style port (push/full); results leave through a queue style port
// (empty/pop), with the oldest result on fired_o..last_o while empty is low.
// A start arms a slot with deadline, period and periodic mark; a stop disarms
// it. A tick visits slots 0..15 in order and emits one fired result for each
// active slot whose deadline is at or below now_i; periodic slots reload to
// now + period, one-shot slots disarm. Every transaction ends with one result
// carrying last_o = 1 and the earliest active deadline (next_valid_o = 0 if
// no slot is armed).
// Timing: a transaction passes through the executor as a dispatch step, a scan
// of the slots at one slot per cycle while the result queue has room, and a
// final result. The first result passes the command queue, the dispatch and
// the result queue before it is visible. A two-entry command queue in front
// lets the next transaction be pushed while one is executing.
// Stall: if the result queue fills, the scan waits on the slot that fires
// until the receiver pops. Reset clears all active and periodic marks and
// empties both queues; deadline and period stores need no clearing.
module software_timer_table_top import stt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [SLOT_W-1:0]  slot_i,
  input  logic [FIELD_W-1:0] deadline_i,
  input  logic [FIELD_W-1:0] period_i,
  input  logic               periodic_i,
  input  logic [FIELD_W-1:0] now_i,
  output logic               empty,
  input  logic               pop,
  output logic               fired_o,
  output logic [SLOT_W-1:0]  fired_slot_o,
  output logic               next_valid_o,
  output logic [FIELD_W-1:0] next_due_o,
  output logic               last_o
);

  cmd_t cmd;
  logic cmd_valid, cmd_take;
  res_t res_in, res_out;
  logic res_push, res_full;

  // front: classify and buffer incoming transactions
  stt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .kind_i      (kind_i),
    .slot_i      (slot_i),
    .deadline_i  (deadline_i),
    .period_i    (period_i),
    .periodic_i  (periodic_i),
    .now_i       (now_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  // back: slot table and scan sequencer
  stt_exec u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  // result queue toward the receiver
  stt_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_i      (res_in),
    .res_full_o (res_full),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res_out)
  );

  assign fired_o      = res_out.fired;
  assign fired_slot_o = res_out.fired_slot;
  assign next_valid_o = res_out.next_valid;
  assign next_due_o   = res_out.next_due;
  assign last_o       = res_out.last;

endmodule

>>> rtl/core/stt_front.sv
module stt_front import stt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [SLOT_W-1:0]   slot_i,
  input  logic [FIELD_W-1:0]  deadline_i,
  input  logic [FIELD_W-1:0]  period_i,
  input  logic                periodic_i,
  input  logic [FIELD_W-1:0]  now_i,
  output logic                cmd_valid_o,
  output cmd_t                cmd_o,
  input  logic                cmd_take_i
);

  cmd_t                 mem_q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CMDQ_CW-1:0]   cnt_q;
  cmd_t                 cmd_in;
  logic                 in_range;
  logic                 do_push, do_pop;

  // start/stop on a slot past the table end do nothing
  assign in_range = int'(slot_i) < SLOTS;

  always_comb begin
    cmd_in.slot     = SLOT_IW'(slot_i);
    cmd_in.deadline = TIME_BITS'(deadline_i);
    cmd_in.period   = TIME_BITS'(period_i);
    cmd_in.periodic = periodic_i;
    cmd_in.now      = TIME_BITS'(now_i);
    case (kind_i)
      KIND_START: cmd_in.op = in_range ? OP_START : OP_NOP;
      KIND_STOP:  cmd_in.op = in_range ? OP_STOP : OP_NOP;
      KIND_TICK:  cmd_in.op = OP_TICK;
      default:    cmd_in.op = OP_NOP;
    endcase
  end

  assign full        = cnt_q == CMDQ_CW'(CMDQ_DEPTH);
  assign cmd_valid_o = cnt_q != '0;
  assign cmd_o       = mem_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_take_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + CMDQ_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + CMDQ_AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CMDQ_CW'(1);
        2'b01:   cnt_q <= cnt_q - CMDQ_CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> rtl/core/stt_exec.sv
module stt_exec import stt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cmd_valid_i,
  input  cmd_t  cmd_i,
  output logic  cmd_take_o,
  output logic  res_push_o,
  output res_t  res_o,
  input  logic  res_full_i
);

  `include "software_timer_table_top_assert.svh"

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FINAL = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [SLOT_IW-1:0]   idx_q, idx_d;
  cmd_t                 cur_q;
  logic                 any_q, any_d;
  logic [TIME_BITS-1:0] best_q, best_d;

  logic                 active_q   [SLOTS];
  logic                 periodic_q [SLOTS];
  logic [TIME_BITS-1:0] dl_q       [SLOTS];
  logic [TIME_BITS-1:0] per_q      [SLOTS];

  logic                 act, per_mark, hit, fire, step, last_idx, eff_act, take_min;
  logic [TIME_BITS-1:0] dl, reload, eff_dl;

  assign act      = active_q[idx_q];
  assign per_mark = periodic_q[idx_q];
  assign dl       = dl_q[idx_q];
  assign reload   = cur_q.now + per_q[idx_q];
  assign hit      = (state_q == ST_SCAN) && (cur_q.op == OP_TICK) && act && (cur_q.now >= dl);
  assign fire     = hit && !res_full_i;
  assign step     = (state_q == ST_SCAN) && !(hit && res_full_i);
  assign last_idx = idx_q == SLOT_IW'(SLOTS - 1);
  // slot state as it stands after this visit
  assign eff_act  = act && !(hit && !per_mark);
  assign eff_dl   = (hit && per_mark) ? reload : dl;
  assign take_min = eff_act && (!any_q || (eff_dl < best_q));

  assign cmd_take_o = (state_q == ST_IDLE) && cmd_valid_i;
  assign res_push_o = fire || ((state_q == ST_FINAL) && !res_full_i);

  always_comb begin
    res_o = '0;
    if (state_q == ST_FINAL) begin
      res_o.next_valid = any_q;
      res_o.next_due   = any_q ? FIELD_W'(best_q) : '0;
      res_o.last       = 1'b1;
    end else begin
      res_o.fired      = 1'b1;
      res_o.fired_slot = SLOT_W'(idx_q);
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    any_d   = any_q;
    best_d  = best_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = ST_SCAN;
          idx_d   = '0;
          any_d   = 1'b0;
        end
      end
      ST_SCAN: begin
        if (step) begin
          if (take_min) begin
            any_d  = 1'b1;
            best_d = eff_dl;
          end
          if (last_idx) begin
            state_d = ST_FINAL;
          end else begin
            idx_d = idx_q + SLOT_IW'(1);
          end
        end
      end
      ST_FINAL: begin
        if (!res_full_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      any_q   <= 1'b0;
      best_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      any_q   <= any_d;
      best_q  <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) begin
      cur_q <= cmd_i;
    end
  end

  // marks: cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        active_q[i]   <= 1'b0;
        periodic_q[i] <= 1'b0;
      end
    end else begin
      if (cmd_take_o && cmd_i.op == OP_START) begin
        active_q[cmd_i.slot]   <= 1'b1;
        periodic_q[cmd_i.slot] <= cmd_i.periodic;
      end else if (cmd_take_o && cmd_i.op == OP_STOP) begin
        active_q[cmd_i.slot] <= 1'b0;
      end else if (fire && !per_mark) begin
        active_q[idx_q] <= 1'b0;
      end
    end
  end

  // deadline and period stores: only read behind an active mark
  always_ff @(posedge clk_i) begin
    if (cmd_take_o && cmd_i.op == OP_START) begin
      dl_q[cmd_i.slot]  <= cmd_i.deadline;
      per_q[cmd_i.slot] <= cmd_i.period;
    end else if (fire && per_mark) begin
      dl_q[idx_q] <= reload;
    end
  end

  `STT_ASSERT_IMP(a_no_push_full, res_push_o, !res_full_i, "result pushed into full queue")
  `STT_ASSERT_IMP(a_take_idle, cmd_take_o, state_q == ST_IDLE, "command taken while busy")
  `STT_ASSERT_NXT(a_final_done, (state_q == ST_FINAL) && res_push_o, state_q == ST_IDLE,
                  "final result did not end the transaction")

endmodule

>>> rtl/core/stt_outq.sv
module stt_outq import stt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  res_push_i,
  input  res_t  res_i,
  output logic  res_full_o,
  output logic  empty,
  input  logic  pop,
  output res_t  res_o
);

  `include "software_timer_table_top_assert.svh"

  res_t               mem_q [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [OUTQ_CW-1:0] cnt_q;
  logic               do_push, do_pop;

  assign res_full_o = cnt_q == OUTQ_CW'(OUTQ_DEPTH);
  assign empty      = cnt_q == '0;
  assign res_o      = mem_q[rd_ptr_q];
  assign do_push    = res_push_i && !res_full_o;
  assign do_pop     = pop && !empty;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + OUTQ_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + OUTQ_AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + OUTQ_CW'(1);
        2'b01:   cnt_q <= cnt_q - OUTQ_CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `STT_ASSERT(a_cnt_bound, cnt_q <= OUTQ_CW'(OUTQ_DEPTH), "result queue count overflow")

endmodule
